[src/segment_intersection_sat_assert.svh]
// Assertion macros for the segment intersection block.
// Used by segment_intersection_sat.sv; depends on nothing else.
`ifndef SEGMENT_INTERSECTION_SAT_ASSERT_SVH
`define SEGMENT_INTERSECTION_SAT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sis assertion failed");
// next-cycle implication
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sis assertion failed");
`else
`define SIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/sis_pkg.sv]
// Shared constants and types for the segment intersection block.
// No dependencies.
package sis_pkg;
	localparam int COORD_BITS_DEF = 32;
	localparam int AXW = 32;       // Q2.30 signed axis component
	localparam int MW = 31;        // normalised magnitude width
	localparam int FRAC = 30;
	localparam int LENW = 32;      // floor sqrt of a 63-bit value
	localparam int RT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam int TOL_W = 31;
	// diff, abs, max, msb, shift, square, sum, root, prep, divide, sign
	localparam int UD_STAGES = 7 + RT_STEPS + 1 + DIV_STEPS + 1;
	typedef logic signed [AXW-1:0] axis_comp_t;
endpackage

[src/sis_unit_dir.sv]
// Pipelined unit direction of a segment: normalise, square root, divide.
// Depends on sis_pkg.
module sis_unit_dir #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	output sis_pkg::axis_comp_t          ux,
	output sis_pkg::axis_comp_t          uy
);
	import sis_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int PBW = $clog2(DW);
	localparam int RW = LENW + 4;
	localparam int NW = 2 * RT_STEPS;

	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [DW-1:0] mx_s2, my_s2, mx_s3, my_s3, m_s3, mx_s4, my_s4;
	logic sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5, sx_s6, sy_s6, sx_s7, sy_s7;
	logic z_s3, z_s4, z_s5, z_s6, z_s7;
	logic [PBW-1:0] p_s4;
	logic [PBW-1:0] p_c;
	logic [DW+FRAC-1:0] wx_c, wy_c;
	logic [MW-1:0] nx_s5, ny_s5, nx_s6, ny_s6, nx_s7, ny_s7;
	logic [2*MW-1:0] sqx_s6, sqy_s6;
	logic [NW-1:0] n_s7;

	// square root pipeline, entry 0 is the summed square
	logic [RW-1:0]   rt_rem_s  [RT_STEPS+1];
	logic [LENW-1:0] rt_root_s [RT_STEPS+1];
	logic [NW-1:0]   rt_n_s    [RT_STEPS+1];
	logic [MW-1:0]   rt_nx_s   [RT_STEPS+1];
	logic [MW-1:0]   rt_ny_s   [RT_STEPS+1];
	logic            rt_sx_s   [RT_STEPS+1];
	logic            rt_sy_s   [RT_STEPS+1];
	logic            rt_z_s    [RT_STEPS+1];

	// divider pipeline, entry 0 is the prepared numerator
	logic [LENW:0]   dv_len_s  [DIV_STEPS+1];
	logic [LENW:0]   dv_rx_s   [DIV_STEPS+1];
	logic [LENW:0]   dv_ry_s   [DIV_STEPS+1];
	logic [MW-1:0]   dv_lx_s   [DIV_STEPS+1];
	logic [MW-1:0]   dv_ly_s   [DIV_STEPS+1];
	logic [MW-1:0]   dv_qx_s   [DIV_STEPS+1];
	logic [MW-1:0]   dv_qy_s   [DIV_STEPS+1];
	logic            dv_sx_s   [DIV_STEPS+1];
	logic            dv_sy_s   [DIV_STEPS+1];
	logic            dv_z_s    [DIV_STEPS+1];

	logic [2*MW-1:0] numx_c, numy_c;
	axis_comp_t ux_q, uy_q;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(qx) - DW'(px);
			dy_s1 <= DW'(qy) - DW'(py);
			mx_s2 <= dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
			my_s2 <= dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
			sx_s2 <= dx_s1[DW-1];
			sy_s2 <= dy_s1[DW-1];
			mx_s3 <= mx_s2;
			my_s3 <= my_s2;
			m_s3  <= (mx_s2 > my_s2) ? mx_s2 : my_s2;
			z_s3  <= (mx_s2 == '0) && (my_s2 == '0);
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			p_s4  <= p_c;
			mx_s4 <= mx_s3;
			my_s4 <= my_s3;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
			z_s4  <= z_s3;
			nx_s5 <= wx_c[MW-1:0];
			ny_s5 <= wy_c[MW-1:0];
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
			z_s5  <= z_s4;
			sqx_s6 <= nx_s5 * nx_s5;
			sqy_s6 <= ny_s5 * ny_s5;
			nx_s6 <= nx_s5;
			ny_s6 <= ny_s5;
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
			z_s6  <= z_s5;
			n_s7  <= NW'(sqx_s6) + NW'(sqy_s6);
			nx_s7 <= nx_s6;
			ny_s7 <= ny_s6;
			sx_s7 <= sx_s6;
			sy_s7 <= sy_s6;
			z_s7  <= z_s6;
		end
	end

	// position of the leading one of the larger magnitude
	always_comb begin
		p_c = '0;
		for (int i = 0; i < DW; i++) begin
			if (m_s3[i]) begin
				p_c = PBW'(i);
			end
		end
	end

	// bring the leading one to bit FRAC, dropping bits shifted out
	assign wx_c = {mx_s4, {FRAC{1'b0}}} >> p_s4;
	assign wy_c = {my_s4, {FRAC{1'b0}}} >> p_s4;

	assign rt_rem_s[0]  = '0;
	assign rt_root_s[0] = '0;
	assign rt_n_s[0]    = n_s7;
	assign rt_nx_s[0]   = nx_s7;
	assign rt_ny_s[0]   = ny_s7;
	assign rt_sx_s[0]   = sx_s7;
	assign rt_sy_s[0]   = sy_s7;
	assign rt_z_s[0]    = z_s7;

	for (genvar k = 0; k < RT_STEPS; k++) begin : g_rt
		logic [RW-1:0] r2, trial;
		logic ge;
		always_comb begin
			r2    = {rt_rem_s[k][RW-3:0], rt_n_s[k][NW-1 -: 2]};
			trial = {{(RW-LENW-2){1'b0}}, rt_root_s[k], 2'b01};
			ge    = r2 >= trial;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k+1]  <= ge ? r2 - trial : r2;
				rt_root_s[k+1] <= {rt_root_s[k][LENW-2:0], ge};
				rt_n_s[k+1]    <= {rt_n_s[k][NW-3:0], 2'b00};
				rt_nx_s[k+1]   <= rt_nx_s[k];
				rt_ny_s[k+1]   <= rt_ny_s[k];
				rt_sx_s[k+1]   <= rt_sx_s[k];
				rt_sy_s[k+1]   <= rt_sy_s[k];
				rt_z_s[k+1]    <= rt_z_s[k];
			end
		end
	end

	// rounded numerator m * 2^30 + len / 2
	always_comb begin
		numx_c = {1'b0, rt_nx_s[RT_STEPS], {FRAC{1'b0}}}
			+ {{MW{1'b0}}, rt_root_s[RT_STEPS][LENW-1:1]};
		numy_c = {1'b0, rt_ny_s[RT_STEPS], {FRAC{1'b0}}}
			+ {{MW{1'b0}}, rt_root_s[RT_STEPS][LENW-1:1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[0] <= {1'b0, rt_root_s[RT_STEPS]};
			dv_rx_s[0]  <= (LENW+1)'(numx_c[2*MW-1:MW]);
			dv_ry_s[0]  <= (LENW+1)'(numy_c[2*MW-1:MW]);
			dv_lx_s[0]  <= numx_c[MW-1:0];
			dv_ly_s[0]  <= numy_c[MW-1:0];
			dv_qx_s[0]  <= '0;
			dv_qy_s[0]  <= '0;
			dv_sx_s[0]  <= rt_sx_s[RT_STEPS];
			dv_sy_s[0]  <= rt_sy_s[RT_STEPS];
			dv_z_s[0]   <= rt_z_s[RT_STEPS];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [LENW:0] r2x, r2y;
		logic gex, gey;
		always_comb begin
			r2x = {dv_rx_s[j][LENW-1:0], dv_lx_s[j][MW-1]};
			r2y = {dv_ry_s[j][LENW-1:0], dv_ly_s[j][MW-1]};
			gex = r2x >= dv_len_s[j];
			gey = r2y >= dv_len_s[j];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[j+1] <= dv_len_s[j];
				dv_rx_s[j+1]  <= gex ? r2x - dv_len_s[j] : r2x;
				dv_ry_s[j+1]  <= gey ? r2y - dv_len_s[j] : r2y;
				dv_lx_s[j+1]  <= {dv_lx_s[j][MW-2:0], 1'b0};
				dv_ly_s[j+1]  <= {dv_ly_s[j][MW-2:0], 1'b0};
				dv_qx_s[j+1]  <= {dv_qx_s[j][MW-2:0], gex};
				dv_qy_s[j+1]  <= {dv_qy_s[j][MW-2:0], gey};
				dv_sx_s[j+1]  <= dv_sx_s[j];
				dv_sy_s[j+1]  <= dv_sy_s[j];
				dv_z_s[j+1]   <= dv_z_s[j];
			end
		end
	end

	// restore signs; a zero-length segment gives a zero axis
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_z_s[DIV_STEPS]) begin
				ux_q <= '0;
				uy_q <= '0;
			end else begin
				ux_q <= dv_sx_s[DIV_STEPS] ? -$signed({1'b0, dv_qx_s[DIV_STEPS]})
					: $signed({1'b0, dv_qx_s[DIV_STEPS]});
				uy_q <= dv_sy_s[DIV_STEPS] ? -$signed({1'b0, dv_qy_s[DIV_STEPS]})
					: $signed({1'b0, dv_qy_s[DIV_STEPS]});
			end
		end
	end

	assign ux = ux_q;
	assign uy = uy_q;
endmodule

[src/segment_intersection_sat.sv]
// Segment intersection by separating axes, fully pipelined.
// One request per cycle, except while a stalled output freezes the pipeline.
// The axis path (square root and two dividers, one bit a stage) sets the depth.
// A stall at the output freezes every stage; no request is lost or repeated.
// arst_n clears the valid bits and the tolerance register.
`include "segment_intersection_sat_assert.svh"
module segment_intersection_sat #(
	parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_BITS-1:0]   ax,
	input  logic signed [COORD_BITS-1:0]   ay,
	input  logic signed [COORD_BITS-1:0]   bx,
	input  logic signed [COORD_BITS-1:0]   by,
	input  logic signed [COORD_BITS-1:0]   cx,
	input  logic signed [COORD_BITS-1:0]   cy,
	input  logic signed [COORD_BITS-1:0]   dx,
	input  logic signed [COORD_BITS-1:0]   dy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           intersecting,
	input  logic                           cfg_wr_en,
	input  logic [sis_pkg::TOL_W-1:0]      cfg_wr_data
);
	import sis_pkg::*;

	localparam int HW   = COORD_BITS - 15;      // coordinate >> 16, signed
	localparam int LW   = 17;                   // low 16 bits, signed positive
	localparam int PHW  = AXW + HW;
	localparam int PLW  = AXW + LW;
	localparam int TW   = COORD_BITS + 35;
	localparam int PW   = TW - FRAC;
	localparam int CW   = ((PW > 32) ? PW : 32) + 1;

	logic en;
	logic [TOL_W-1:0] tol_q;
	logic [UD_STAGES-1:0] vld_dly;
	logic signed [COORD_BITS-1:0] pt_dly [UD_STAGES][8];
	axis_comp_t ux0, uy0, ux1, uy1;
	axis_comp_t axc [4][2];
	logic signed [HW-1:0] xh_c [8];
	logic signed [LW-1:0] xl_c [8];
	logic signed [COORD_BITS-1:0] sh_c [8];

	logic [4:0] vld_q;
	logic signed [PHW-1:0]  ph_s1 [4][4][2];
	logic signed [PLW-1:0]  pl_s1 [4][4][2];
	logic signed [PHW:0]    hi_s2 [4][4];
	logic signed [PLW:0]    lo_s2 [4][4];
	logic signed [PW-1:0]   pr_s3 [4][4];
	logic signed [PW-1:0]   mn1_s4 [4], mx1_s4 [4], mn2_s4 [4], mx2_s4 [4];
	logic [3:0] sep_c;
	logic signed [CW-1:0] tolc;
	logic intersecting_q;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly <= '0;
			vld_q   <= '0;
		end else if (en) begin
			vld_dly <= {vld_dly[UD_STAGES-2:0], in_valid};
			vld_q   <= {vld_q[3:0], vld_dly[UD_STAGES-1]};
		end
	end

	// hold the endpoints alongside the axis pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			pt_dly[0] <= '{ax, ay, bx, by, cx, cy, dx, dy};
			for (int i = 1; i < UD_STAGES; i++) begin
				pt_dly[i] <= pt_dly[i-1];
			end
		end
	end

	sis_unit_dir #(.COORD_BITS(COORD_BITS)) u_dir_ab (
		.clk (clk), .en (en), .px (ax), .py (ay), .qx (bx), .qy (by),
		.ux (ux0), .uy (uy0)
	);

	sis_unit_dir #(.COORD_BITS(COORD_BITS)) u_dir_cd (
		.clk (clk), .en (en), .px (cx), .py (cy), .qx (dx), .qy (dy),
		.ux (ux1), .uy (uy1)
	);

	// axes: AB direction, AB normal, CD direction, CD normal, as (x, y) terms
	always_comb begin
		axc[0][0] = ux0;
		axc[0][1] = uy0;
		axc[1][0] = ux0;
		axc[1][1] = uy0;
		axc[2][0] = ux1;
		axc[2][1] = uy1;
		axc[3][0] = ux1;
		axc[3][1] = uy1;
		for (int i = 0; i < 8; i++) begin
			sh_c[i] = pt_dly[UD_STAGES-1][i] >>> 16;
			xh_c[i] = sh_c[i][HW-1:0];
			xl_c[i] = $signed({1'b0, pt_dly[UD_STAGES-1][i][15:0]});
		end
	end

	// split products; a normal pairs ux with y and uy with x
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int k = 0; k < 4; k++) begin
					if (a == 1 || a == 3) begin
						ph_s1[a][k][0] <= axc[a][0] * xh_c[2*k+1];
						ph_s1[a][k][1] <= axc[a][1] * xh_c[2*k];
						pl_s1[a][k][0] <= axc[a][0] * xl_c[2*k+1];
						pl_s1[a][k][1] <= axc[a][1] * xl_c[2*k];
					end else begin
						ph_s1[a][k][0] <= axc[a][0] * xh_c[2*k];
						ph_s1[a][k][1] <= axc[a][1] * xh_c[2*k+1];
						pl_s1[a][k][0] <= axc[a][0] * xl_c[2*k];
						pl_s1[a][k][1] <= axc[a][1] * xl_c[2*k+1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int k = 0; k < 4; k++) begin
					if (a == 1 || a == 3) begin
						hi_s2[a][k] <= (PHW+1)'(ph_s1[a][k][0]) - (PHW+1)'(ph_s1[a][k][1]);
						lo_s2[a][k] <= (PLW+1)'(pl_s1[a][k][0]) - (PLW+1)'(pl_s1[a][k][1]);
					end else begin
						hi_s2[a][k] <= (PHW+1)'(ph_s1[a][k][0]) + (PHW+1)'(ph_s1[a][k][1]);
						lo_s2[a][k] <= (PLW+1)'(pl_s1[a][k][0]) + (PLW+1)'(pl_s1[a][k][1]);
					end
				end
			end
		end
	end

	// exact sum, then floor by 2^30
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				for (int k = 0; k < 4; k++) begin
					pr_s3[a][k] <= PW'(((TW'(hi_s2[a][k]) <<< 16) + TW'(lo_s2[a][k])) >>> FRAC);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 4; a++) begin
				mn1_s4[a] <= (pr_s3[a][0] > pr_s3[a][1]) ? pr_s3[a][1] : pr_s3[a][0];
				mx1_s4[a] <= (pr_s3[a][0] > pr_s3[a][1]) ? pr_s3[a][0] : pr_s3[a][1];
				mn2_s4[a] <= (pr_s3[a][2] > pr_s3[a][3]) ? pr_s3[a][3] : pr_s3[a][2];
				mx2_s4[a] <= (pr_s3[a][2] > pr_s3[a][3]) ? pr_s3[a][2] : pr_s3[a][3];
			end
		end
	end

	assign tolc = $signed(CW'(tol_q));

	always_comb begin
		for (int a = 0; a < 4; a++) begin
			sep_c[a] = (CW'(mx1_s4[a]) <= CW'(mn2_s4[a]) + tolc)
				|| (CW'(mn1_s4[a]) + tolc >= CW'(mx2_s4[a]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			intersecting_q <= !(|sep_c);
		end
	end

	assign out_valid    = vld_q[4];
	assign intersecting = intersecting_q;

	`SIS_ASSERT_NEXT(a_enter, clk, arst_n, !in_stall, vld_dly[0] == $past(in_valid))
	`SIS_ASSERT_NEXT(a_freeze, clk, arst_n, in_stall, $stable(vld_dly) && $stable(vld_q))
	`SIS_ASSERT_NEXT(a_tol, clk, arst_n, cfg_wr_en, tol_q == $past(cfg_wr_data))
	`SIS_ASSERT_IMPLY(a_out_src, clk, arst_n, $rose(out_valid), $past(vld_q[3]))
endmodule

[bench/segment_intersection_sat_tb.sv]
// Self-checking bench for segment_intersection_sat: segment pairs in, intersect flag checked.
// Needs sis_pkg, segment_intersection_sat, sis_unit_dir and the assertion header from the RTL.
`timescale 1ns / 1ps
module segment_intersection_sat_tb;
	import sis_pkg::*;

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
	typedef struct {
		coord_t p [8];
	} seg_pair_t;

	localparam int DRAIN_CYCLES = UD_STAGES + 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	coord_t ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0, dx = '0, dy = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic intersecting;
	logic cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;

	seg_pair_t pending_pairs [$];
	bit hit_expected [$];
	logic [TOL_W-1:0] tol_model = '0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit taken = 1'b0;
	int fails = 0;
	int checked = 0;
	int hits_seen = 0;

	segment_intersection_sat i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .dx(dx), .dy(dy),
		.out_valid(out_valid), .out_stall(out_stall), .intersecting(intersecting),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic void add_pair(seg_pair_t s);
		pending_pairs = {pending_pairs, s};
	endfunction

	function automatic void add_expected(bit e);
		hit_expected = {hit_expected, e};
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void unit_axis(input longint px, py, qx, qy, output longint ux, uy);
		longint ddx, ddy;
		longint unsigned mx, my, m, len, rx, ry;
		ddx = qx - px;
		ddy = qy - py;
		mx = (ddx < 0) ? -ddx : ddx;
		my = (ddy < 0) ? -ddy : ddy;
		ux = 0;
		uy = 0;
		if (mx == 0 && my == 0)
			return;
		m = (mx > my) ? mx : my;
		while (m >= (64'd1 << 31)) begin
			mx >>= 1; my >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			mx <<= 1; my <<= 1; m <<= 1;
		end
		len = int_sqrt(mx * mx + my * my);
		rx = ((mx << 30) + len / 2) / len;
		ry = ((my << 30) + len / 2) / len;
		ux = (ddx < 0) ? -longint'(rx) : longint'(rx);
		uy = (ddy < 0) ? -longint'(ry) : longint'(ry);
	endfunction

	// products stay below 2^62, so the exact sum fits and >>> is the floor
	function automatic longint project(longint ux, uy, longint x, y);
		return (ux * x + uy * y) >>> 30;
	endfunction

	function automatic bit axis_separates(longint ux, uy, seg_pair_t s, longint tol);
		longint a0, a1, b0, b1, t;
		a0 = project(ux, uy, s.p[0], s.p[1]);
		a1 = project(ux, uy, s.p[2], s.p[3]);
		b0 = project(ux, uy, s.p[4], s.p[5]);
		b1 = project(ux, uy, s.p[6], s.p[7]);
		if (a0 > a1) begin t = a0; a0 = a1; a1 = t; end
		if (b0 > b1) begin t = b0; b0 = b1; b1 = t; end
		return (a1 <= b0 + tol) || (a0 + tol >= b1);
	endfunction

	function automatic bit predict_hit(seg_pair_t s, logic [TOL_W-1:0] tol_reg);
		longint u0x, u0y, u1x, u1y, tol;
		tol = longint'({1'b0, tol_reg});
		unit_axis(s.p[0], s.p[1], s.p[2], s.p[3], u0x, u0y);
		unit_axis(s.p[4], s.p[5], s.p[6], s.p[7], u1x, u1y);
		if (axis_separates(u0x, u0y, s, tol)) return 1'b0;
		if (axis_separates(u1x, u1y, s, tol)) return 1'b0;
		if (axis_separates(-u0y, u0x, s, tol)) return 1'b0;
		if (axis_separates(-u1y, u1x, s, tol)) return 1'b0;
		return 1'b1;
	endfunction

	function automatic seg_pair_t make_pair(longint v [8]);
		seg_pair_t s;
		foreach (v[i])
			s.p[i] = coord_t'(v[i]);
		return s;
	endfunction

	function automatic seg_pair_t random_pair();
		seg_pair_t s;
		int kind;
		int span;
		kind = $urandom_range(99);
		span = $urandom_range(24, 8);
		foreach (s.p[i]) begin
			if (kind < 15)
				s.p[i] = coord_t'($urandom);
			else
				s.p[i] = coord_t'($signed($urandom_range((1 << span) - 1)) - (1 << (span - 1)));
		end
		// degenerate segment, or a shared endpoint
		if (kind >= 90 && kind < 95) begin
			s.p[2] = s.p[0]; s.p[3] = s.p[1];
		end else if (kind >= 95) begin
			s.p[4] = s.p[2]; s.p[5] = s.p[3];
		end
		return s;
	endfunction

	// driver: change at the falling edge, hold a stalled request
	always @(negedge clk) begin
		if (!in_valid || taken) begin
			if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				seg_pair_t s;
				s = pending_pairs.pop_front();
				ax <= s.p[0]; ay <= s.p[1]; bx <= s.p[2]; by <= s.p[3];
				cx <= s.p[4]; cy <= s.p[5]; dx <= s.p[6]; dy <= s.p[7];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// accept requests and check results at the rising edge
	always @(posedge clk) begin
		seg_pair_t s;
		taken <= in_valid && !in_stall && arst_n;
		if (arst_n && in_valid && !in_stall) begin
			s.p[0] = ax; s.p[1] = ay; s.p[2] = bx; s.p[3] = by;
			s.p[4] = cx; s.p[5] = cy; s.p[6] = dx; s.p[7] = dy;
			add_expected(predict_hit(s, tol_model));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (hit_expected.size() == 0) begin
				fails++;
				$display("%0t: unexpected result, expected none, actual %0b", $realtime,
					intersecting);
			end else begin
				bit e;
				e = hit_expected.pop_front();
				checked++;
				hits_seen += intersecting;
				if (intersecting !== e) begin
					fails++;
					$display("%0t: intersecting expected %0b, actual %0b", $realtime, e,
						intersecting);
				end
			end
		end
	end

	task automatic drain();
		while (pending_pairs.size() > 0 || in_valid || hit_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [TOL_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		tol_model = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_directed();
		longint mx, mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		add_pair(make_pair('{0, 0, 65536, 65536, 0, 65536, 65536, 0}));
		add_pair(make_pair('{0, 0, 0, 0, -65536, 0, 65536, 0}));
		add_pair(make_pair('{-65536, 0, 65536, 0, 0, 0, 0, 0}));
		add_pair(make_pair('{0, 0, 65536, 0, 65536, 0, 131072, 0}));
		add_pair(make_pair('{0, 0, 65536, 0, 0, 65536, 65536, 65536}));
		add_pair(make_pair('{0, 0, 131072, 0, 65536, 0, 196608, 0}));
		add_pair(make_pair('{0, 0, 65536, 0, 65536, -65536, 65536, 65536}));
		add_pair(make_pair('{0, 0, 65536, 0, 65537, -65536, 65537, 65536}));
		add_pair(make_pair('{mn, mn, mx, mx, mn, mx, mx, mn}));
		add_pair(make_pair('{mx, mx, mn, mn, mx, mn, mn, mx}));
		add_pair(make_pair('{mn, 0, mx, 0, 0, mn, 0, mx}));
		add_pair(make_pair('{mn, mn, mn, mn, mx, mx, mx, mx}));
		add_pair(make_pair('{mx, mn, mn, mx, -1, -1, 1, 1}));
		add_pair(make_pair('{-1, -1, 1, 1, -1, 1, 1, -1}));
		add_pair(make_pair('{0, 0, 1, 0, 0, 0, 0, 1}));
		add_pair(make_pair('{-3, 7, 5, -2, 1, -9, -4, 6}));
		add_pair(make_pair('{0, 0, 65536, 655360, 1000, 1, 2000, 327680}));
		add_pair(make_pair('{-1, -1, -1, -1, -1, -1, -1, -1}));
	endtask

	task automatic queue_random(int n);
		repeat (n) add_pair(random_pair());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 7;
		recv_idle_pct = 66;
		queue_directed();
		drain();
		set_tolerance(31'h7fff_ffff);
		queue_directed();
		queue_random(60);
		drain();

		send_idle_pct = 66;
		recv_idle_pct = 7;
		set_tolerance(31'd65536);
		queue_directed();
		queue_random(150);
		drain();
		set_tolerance(31'd1);
		queue_random(150);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_tolerance(31'($urandom_range(1 << 20)));
		queue_random(60);
		// hold off until the pipeline is empty, then resume at full rate
		drain();
		set_tolerance('0);
		queue_directed();
		queue_random(60);
		drain();

		$display("Checked %0d results (%0d intersecting) over six tolerance settings,",
			checked, hits_seen);
		$display("with directed extremes, degenerate segments and random back-pressure.");
		if (fails == 0)
			$display("segment_intersection_sat: match");
		else
			$display("segment_intersection_sat: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("segment_intersection_sat: mismatch");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/sis_pkg.sv
src/sis_unit_dir.sv
src/segment_intersection_sat.sv
bench/segment_intersection_sat_tb.sv
